### design/trctb_pkg.sv
package trctb_pkg;

  // Storage depth of each bank; the slot field is four bits wide.
  localparam int BANK_DEPTH = 16;
  localparam int SLOT_W     = 4;
  localparam int COUNT_W    = 8;
  localparam int USED_W     = 5;

  // Prescaler and slow_ratio value after reset.
  localparam logic [COUNT_W-1:0] RATIO_RESET = 8'd10;

  typedef enum logic [1:0] {
    REQ_TICK  = 2'd0,
    REQ_REG   = 2'd1,
    REQ_WRITE = 2'd2,
    REQ_READ  = 2'd3
  } req_t;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_FULL    = 2'd1,
    ST_BADSLOT = 2'd2
  } status_t;

  typedef logic [COUNT_W-1:0] count_t;

endpackage

### design/two_rate_countdown_timer_bank.sv
// Two banks of 8-bit countdown timers, a fast bank and a slow bank.
// Requests arrive on the s_axis channel: tuser carries the request type and
// the bank, tdata the slot and the value. A tick request decrements every
// registered fast counter above zero and steps the prescaler; each time the
// prescaler reaches zero it is reloaded from slow_ratio and the registered
// slow counters above zero decrement as well. Register requests hand out the
// next free slot of a bank, write and read requests load or return a count.
// Every request produces exactly one result on the m_axis channel.
// The result is loaded into the output register at the clock edge that takes
// the request. One request is taken every cycle while the receiver keeps up;
// the rate is set by the single output register, which accepts a new result
// whenever it is empty or is being emptied in the same cycle.
// When the receiver stalls, the result is held and s_axis_tready falls until
// it is taken. The cfg channel writes slow_ratio and is always ready; the new
// ratio takes effect at the next prescaler reload.
// Reset clears all counts and allocations, and sets slow_ratio and the
// prescaler to ten. The block is ready in the first cycle after reset.
module two_rate_countdown_timer_bank
  import trctb_pkg::*;
#(
  parameter int FAST_SLOTS = 16,
  parameter int SLOW_SLOTS = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,  // [3:0] slot, [11:4] value, [15:12] zero
  input  logic [2:0]  s_axis_tuser,  // [1:0] req_type, [2] bank
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata,  // [3:0] slot_given, [11:4] count_value, [15:12] zero
  output logic [2:0]  m_axis_tuser,  // [1:0] status, [2] slow_served
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [7:0]  cfg_data
);

  // Number of slots that may be handed out in each bank.
  localparam logic [USED_W-1:0] FAST_LIMIT = USED_W'(FAST_SLOTS);
  localparam logic [USED_W-1:0] SLOW_LIMIT = USED_W'(SLOW_SLOTS);

  count_t fast_counts [BANK_DEPTH];
  count_t slow_counts [BANK_DEPTH];
  count_t fast_counts_next [BANK_DEPTH];
  count_t slow_counts_next [BANK_DEPTH];

  logic [USED_W-1:0] fast_used, fast_used_next;
  logic [USED_W-1:0] slow_used, slow_used_next;
  count_t            tick_prescaler, tick_prescaler_next;
  count_t            slow_ratio;

  // Output register contents.
  logic              out_valid;
  status_t           out_status;
  logic [SLOT_W-1:0] out_slot_given;
  count_t            out_count;
  logic              out_served;

  // Result of the request at the input.
  status_t           status_next;
  logic [SLOT_W-1:0] slot_given_next;
  count_t            count_next;
  logic              served_next;

  req_t              req;
  logic              bank;
  logic [SLOT_W-1:0] slot;
  count_t            value;
  logic              accept;

  logic [USED_W-1:0] sel_used;
  logic [USED_W-1:0] sel_limit;
  logic              slot_ok;
  count_t            presc_dec;

  assign req   = req_t'(s_axis_tuser[1:0]);
  assign bank  = s_axis_tuser[2];
  assign slot  = s_axis_tdata[3:0];
  assign value = s_axis_tdata[11:4];

  // The output register takes a new result when it is empty or drained now.
  assign s_axis_tready = !out_valid || m_axis_tready;
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign cfg_ready     = 1'b1;

  assign sel_used  = bank ? slow_used : fast_used;
  assign sel_limit = bank ? SLOW_LIMIT : FAST_LIMIT;
  // Slots are handed out in order from zero, so a slot is registered exactly
  // when it lies below the bank's allocation count.
  assign slot_ok   = {1'b0, slot} < sel_used;
  assign presc_dec = tick_prescaler - 8'd1;

  always_comb begin
    fast_counts_next    = fast_counts;
    slow_counts_next    = slow_counts;
    fast_used_next      = fast_used;
    slow_used_next      = slow_used;
    tick_prescaler_next = tick_prescaler;
    status_next         = ST_OK;
    slot_given_next     = '0;
    count_next          = '0;
    served_next         = 1'b0;

    unique case (req)
      REQ_TICK: begin
        for (int k = 0; k < BANK_DEPTH; k++) begin
          if (USED_W'(k) < fast_used && fast_counts[k] != '0) begin
            fast_counts_next[k] = fast_counts[k] - 8'd1;
          end
        end
        // A ratio of zero reloads zero, which wraps to 255 on the next tick.
        if (presc_dec == '0) begin
          tick_prescaler_next = slow_ratio;
          served_next         = 1'b1;
          for (int k = 0; k < BANK_DEPTH; k++) begin
            if (USED_W'(k) < slow_used && slow_counts[k] != '0) begin
              slow_counts_next[k] = slow_counts[k] - 8'd1;
            end
          end
        end else begin
          tick_prescaler_next = presc_dec;
        end
      end
      REQ_REG: begin
        if (sel_used >= sel_limit) begin
          status_next = ST_FULL;
        end else begin
          slot_given_next = sel_used[SLOT_W-1:0];
          if (bank) begin
            slow_counts_next[sel_used[SLOT_W-1:0]] = value;
            slow_used_next = slow_used + 5'd1;
          end else begin
            fast_counts_next[sel_used[SLOT_W-1:0]] = value;
            fast_used_next = fast_used + 5'd1;
          end
        end
      end
      REQ_WRITE: begin
        if (!slot_ok) begin
          status_next = ST_BADSLOT;
        end else if (bank) begin
          slow_counts_next[slot] = value;
        end else begin
          fast_counts_next[slot] = value;
        end
      end
      REQ_READ: begin
        if (!slot_ok) begin
          status_next = ST_BADSLOT;
        end else begin
          count_next = bank ? slow_counts[slot] : fast_counts[slot];
        end
      end
    endcase
  end

  // Timer state and configuration.
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < BANK_DEPTH; k++) begin
        fast_counts[k] <= '0;
        slow_counts[k] <= '0;
      end
      fast_used      <= '0;
      slow_used      <= '0;
      tick_prescaler <= RATIO_RESET;
      slow_ratio     <= RATIO_RESET;
    end else begin
      if (accept) begin
        fast_counts    <= fast_counts_next;
        slow_counts    <= slow_counts_next;
        fast_used      <= fast_used_next;
        slow_used      <= slow_used_next;
        tick_prescaler <= tick_prescaler_next;
      end
      if (cfg_valid && cfg_ready) begin
        slow_ratio <= cfg_data;
      end
    end
  end

  // Output register: valid flag under reset, payload loaded on each request.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (accept) begin
      out_valid <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_status     <= status_next;
      out_slot_given <= slot_given_next;
      out_count      <= count_next;
      out_served     <= served_next;
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {4'd0, out_count, out_slot_given};
  assign m_axis_tuser  = {out_served, out_status};

endmodule

### tb/two_rate_countdown_timer_bank_tb.sv
module two_rate_countdown_timer_bank_tb;
  import trctb_pkg::*;

  localparam int FAST_SLOTS = 16;
  localparam int SLOW_SLOTS = 16;
  localparam int HALF_PERIOD = 4;
  localparam int RESET_CYCLES = 11;
  localparam int IDLE_PCT = 24;
  // The ratio write waits until idle_cycles reaches SETTLE_CYCLES, so that no
  // request can still be in flight.
  localparam int SETTLE_CYCLES = 2;
  localparam int TAIL_CYCLES = 10;
  localparam int TIMEOUT_CYCLES = 200000;

  // What sits in the pending queue: a request for the block, a write of
  // slow_ratio, or a pause until every outstanding result has come back.
  typedef enum logic [1:0] {
    JOB_REQ,
    JOB_RATIO,
    JOB_DRAIN
  } job_kind_t;

  typedef struct {
    job_kind_t          kind;
    req_t               req;
    logic               bank;
    logic [SLOT_W-1:0]  slot;
    count_t             value;   // start or new count; the ratio for JOB_RATIO
  } job_t;

  typedef struct packed {
    status_t            status;
    logic [SLOT_W-1:0]  slot_given;
    count_t             count_value;
    logic               slow_served;
  } timer_result_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [15:0] s_axis_tdata = '0;   // [3:0] slot, [11:4] value, [15:12] zero
  logic [2:0]  s_axis_tuser = '0;   // [1:0] req_type, [2] bank
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [15:0] m_axis_tdata;        // [3:0] slot_given, [11:4] count_value, [15:12] zero
  logic [2:0]  m_axis_tuser;        // [1:0] status, [2] slow_served
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [7:0]  cfg_data = '0;

  two_rate_countdown_timer_bank #(
    .FAST_SLOTS(FAST_SLOTS),
    .SLOW_SLOTS(SLOW_SLOTS)
  ) dut (
    .clk(clk),
    .rst(rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata),
    .s_axis_tuser(s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata),
    .m_axis_tuser(m_axis_tuser),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_data(cfg_data)
  );

  always #HALF_PERIOD clk = ~clk;

  // Our own copy of the timer state, advanced once per accepted request.
  count_t            fast_cnt [BANK_DEPTH];
  count_t            slow_cnt [BANK_DEPTH];
  logic [USED_W-1:0] fast_used;
  logic [USED_W-1:0] slow_used;
  count_t            prescale;
  count_t            ratio_now;

  job_t          jobs[$];
  timer_result_t awaited_results[$];
  int            planned_used [2];

  // Handshake flags passed from the sampling edge to the driving edge.
  logic req_taken = 1'b0;
  logic ratio_taken = 1'b0;
  logic stimulus_done = 1'b0;
  int   idle_cycles = 0;
  int   accepted = 0;
  logic calm;

  int errors = 0;
  int checked = 0;
  int n_ticks = 0, n_served = 0, n_regs = 0, n_full = 0;
  int n_writes = 0, n_reads = 0, n_badslot = 0, n_ratio_writes = 0;

  // A long run of requests where neither side ever holds back.
  assign calm = (accepted >= 300) && (accepted < 450);

  // Works out the single result of one request and updates the timer state.
  function automatic timer_result_t timer_bank_apply(req_t kind, logic bank,
                                                     logic [SLOT_W-1:0] slot,
                                                     count_t value);
    timer_result_t     res;
    logic [USED_W-1:0] used;
    int                size;
    res = '0;
    used = bank ? slow_used : fast_used;
    size = bank ? SLOW_SLOTS : FAST_SLOTS;
    case (kind)
      REQ_TICK: begin
        n_ticks++;
        for (int k = 0; k < BANK_DEPTH; k++) begin
          if (k < fast_used && fast_cnt[k] != 0) fast_cnt[k] = fast_cnt[k] - 1'b1;
        end
        // The prescaler wraps, so a ratio of zero serves the slow bank every
        // 256 ticks.
        prescale = prescale - 1'b1;
        if (prescale == 0) begin
          prescale = ratio_now;
          for (int k = 0; k < BANK_DEPTH; k++) begin
            if (k < slow_used && slow_cnt[k] != 0) slow_cnt[k] = slow_cnt[k] - 1'b1;
          end
          res.slow_served = 1'b1;
          n_served++;
        end
      end
      REQ_REG: begin
        n_regs++;
        if (used >= size) begin
          res.status = ST_FULL;
          n_full++;
        end else begin
          res.slot_given = used[SLOT_W-1:0];
          if (bank) begin
            slow_cnt[used[SLOT_W-1:0]] = value;
            slow_used = slow_used + 1'b1;
          end else begin
            fast_cnt[used[SLOT_W-1:0]] = value;
            fast_used = fast_used + 1'b1;
          end
        end
      end
      default: begin
        if (kind == REQ_WRITE) n_writes++;
        else n_reads++;
        if (slot >= used) begin
          res.status = ST_BADSLOT;
          n_badslot++;
        end else if (kind == REQ_WRITE) begin
          if (bank) slow_cnt[slot] = value;
          else fast_cnt[slot] = value;
        end else begin
          res.count_value = bank ? slow_cnt[slot] : fast_cnt[slot];
        end
      end
    endcase
    return res;
  endfunction

  task automatic add_request(req_t req, logic bank, int slot, int value);
    job_t j;
    j.kind = JOB_REQ;
    j.req = req;
    j.bank = bank;
    j.slot = SLOT_W'(slot);
    j.value = COUNT_W'(value);
    jobs.push_back(j);
    // Registration succeeds exactly while the bank has room, so the generator
    // can keep track of which slots will be live when a request arrives.
    if (req == REQ_REG && planned_used[bank] < (bank ? SLOW_SLOTS : FAST_SLOTS))
      planned_used[bank]++;
  endtask

  task automatic add_control(job_kind_t kind, int ratio);
    job_t j;
    j.kind = kind;
    j.req = REQ_TICK;
    j.bank = 1'b0;
    j.slot = '0;
    j.value = COUNT_W'(ratio);
    jobs.push_back(j);
  endtask

  // Random requests: most reads and writes aim at slots that will be
  // registered by then, the rest at any slot. Small counts are favoured so
  // that counters regularly run down to zero and stay there.
  task automatic add_random_phase(int count, int tick_pct);
    logic bank;
    int   slot, value, pick;
    for (int n = 0; n < count; n++) begin
      bank = 1'($urandom_range(1));
      value = $urandom_range(1) ? $urandom_range(15) : $urandom_range(255);
      if (planned_used[bank] > 0 && $urandom_range(99) < 80)
        slot = $urandom_range(planned_used[bank] - 1);
      else
        slot = $urandom_range(15);
      pick = $urandom_range(99);
      if (pick < tick_pct) begin
        add_request(REQ_TICK, bank, $urandom_range(15), $urandom_range(255));
      end else begin
        pick = $urandom_range(99);
        if (pick < 12) add_request(REQ_REG, bank, slot, value);
        else if (pick < 52) add_request(REQ_WRITE, bank, slot, value);
        else add_request(REQ_READ, bank, slot, value);
      end
      if (n == count / 2 && tick_pct < 50) add_control(JOB_DRAIN, 0);
    end
  endtask

  // Driver: presents the next pending request, ratio write or pause on the
  // falling edge. Each driven signal gets a single assignment per edge.
  always @(negedge clk) begin : driver
    logic send_next;
    logic ratio_next;
    send_next = s_axis_tvalid && !req_taken;
    ratio_next = cfg_valid && !ratio_taken;
    req_taken = 1'b0;
    ratio_taken = 1'b0;
    if (!rst && !send_next && !ratio_next) begin
      if (jobs.size() == 0) begin
        stimulus_done = 1'b1;
      end else begin
        case (jobs[0].kind)
          JOB_REQ: begin
            if (calm || $urandom_range(99) >= IDLE_PCT) begin
              s_axis_tuser <= {jobs[0].bank, jobs[0].req};
              s_axis_tdata <= {4'b0, jobs[0].value, jobs[0].slot};
              send_next = 1'b1;
              jobs.pop_front();
            end
          end
          JOB_RATIO: begin
            if (awaited_results.size() == 0 && idle_cycles >= SETTLE_CYCLES) begin
              cfg_data <= jobs[0].value;
              ratio_next = 1'b1;
              jobs.pop_front();
            end
          end
          default: begin
            if (awaited_results.size() == 0) jobs.pop_front();
          end
        endcase
      end
    end
    s_axis_tvalid <= send_next;
    cfg_valid <= ratio_next;
    m_axis_tready <= !rst && (calm || $urandom_range(99) >= IDLE_PCT);
  end

  // Monitor: on the rising edge, checks the result being handed over against
  // the oldest expectation, then predicts the result of any request taken.
  always @(posedge clk) begin : monitor
    timer_result_t want;
    if (!rst) begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (awaited_results.size() == 0) begin
          $error("result with none expected: status %0d slot_given %0d count_value %0d",
                 m_axis_tuser[1:0], m_axis_tdata[3:0], m_axis_tdata[11:4]);
          errors++;
        end else begin
          want = awaited_results.pop_front();
          checked++;
          if (m_axis_tuser[1:0] !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, m_axis_tuser[1:0]);
            errors++;
          end
          if (m_axis_tuser[2] !== want.slow_served) begin
            $error("slow_served: expected %0d, got %0d", want.slow_served, m_axis_tuser[2]);
            errors++;
          end
          if (m_axis_tdata[3:0] !== want.slot_given) begin
            $error("slot_given: expected %0d, got %0d", want.slot_given, m_axis_tdata[3:0]);
            errors++;
          end
          if (m_axis_tdata[11:4] !== want.count_value) begin
            $error("count_value: expected %0d, got %0d", want.count_value,
                   m_axis_tdata[11:4]);
            errors++;
          end
          if (m_axis_tdata[15:12] !== 4'b0) begin
            $error("tdata padding: expected 0, got %0d", m_axis_tdata[15:12]);
            errors++;
          end
        end
      end
      if (s_axis_tvalid && s_axis_tready) begin
        awaited_results.push_back(timer_bank_apply(req_t'(s_axis_tuser[1:0]),
                                                   s_axis_tuser[2], s_axis_tdata[3:0],
                                                   s_axis_tdata[11:4]));
        req_taken = 1'b1;
        accepted++;
      end
      if (cfg_valid && cfg_ready) begin
        // The running prescaler is left alone; the ratio is used at the next
        // reload.
        ratio_now = cfg_data;
        ratio_taken = 1'b1;
        n_ratio_writes++;
      end
      if (awaited_results.size() == 0 && !s_axis_tvalid && !m_axis_tvalid)
        idle_cycles++;
      else
        idle_cycles = 0;
    end
  end

  initial begin
    for (int k = 0; k < BANK_DEPTH; k++) begin
      fast_cnt[k] = '0;
      slow_cnt[k] = '0;
    end
    fast_used = '0;
    slow_used = '0;
    prescale = RATIO_RESET;
    ratio_now = RATIO_RESET;
    planned_used[0] = 0;
    planned_used[1] = 0;

    // Directed opening: a tick whose other fields are ignored, requests to
    // empty banks, extreme start counts, ten ticks so that the slow bank is
    // served once at the reset ratio, and counters held at zero.
    add_request(REQ_TICK, 1'b1, 15, 255);
    add_request(REQ_READ, 1'b0, 0, 0);
    add_request(REQ_WRITE, 1'b1, 15, 255);
    add_request(REQ_REG, 1'b0, 0, 255);
    add_request(REQ_REG, 1'b0, 15, 1);
    add_request(REQ_REG, 1'b1, 0, 0);
    add_request(REQ_REG, 1'b1, 0, 255);
    add_request(REQ_READ, 1'b0, 0, 0);
    add_request(REQ_READ, 1'b0, 1, 0);
    add_request(REQ_READ, 1'b0, 2, 0);
    for (int n = 0; n < 9; n++) add_request(REQ_TICK, n[0], n, 0);
    add_request(REQ_READ, 1'b0, 1, 0);
    add_request(REQ_READ, 1'b1, 0, 0);
    add_request(REQ_READ, 1'b1, 1, 0);
    add_request(REQ_WRITE, 1'b0, 0, 0);
    add_request(REQ_READ, 1'b0, 0, 0);
    add_request(REQ_READ, 1'b1, 15, 0);

    // Random phases under several ratios. Ratio 1 follows the reset value so
    // that a ratio of zero, written next, is picked up at once and its wrap
    // to 256 ticks is seen within a tick-heavy phase.
    add_control(JOB_RATIO, 1);
    add_random_phase(150, 40);
    add_control(JOB_RATIO, 0);
    add_random_phase(400, 80);
    add_control(JOB_RATIO, 255);
    add_random_phase(330, 85);
    add_control(JOB_RATIO, $urandom_range(2, 254));
    add_random_phase(180, 40);
    add_control(JOB_RATIO, $urandom_range(255));
    add_random_phase(170, 40);

    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    while (!(stimulus_done && awaited_results.size() == 0)) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("Ran %0d requests: %0d ticks with %0d slow-bank services, %0d registrations",
             accepted, n_ticks, n_served, n_regs);
    $display("(%0d bank full), %0d writes and %0d reads (%0d unregistered), %0d ratio writes.",
             n_full, n_writes, n_reads, n_badslot, n_ratio_writes);
    if (errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  initial begin
    #(2 * HALF_PERIOD * TIMEOUT_CYCLES);
    $display("Some tests failed");
    $finish;
  end

endmodule
